// ----- src/rpi_pkg.sv -----
// ----------------------------------------------------------------------------
// Ray / plane intersection package
// Shared constants, register indexes and payload types.
// ----------------------------------------------------------------------------
package rpi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_STEPS = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_A      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_B      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_C      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET = 8'd3;

    typedef struct packed {
        logic signed [WORD_W-1:0] start_x;
        logic signed [WORD_W-1:0] start_y;
        logic signed [WORD_W-1:0] start_z;
        logic signed [WORD_W-1:0] dir_x;
        logic signed [WORD_W-1:0] dir_y;
        logic signed [WORD_W-1:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] hit_x;
        logic signed [WORD_W-1:0] hit_y;
        logic signed [WORD_W-1:0] hit_z;
        logic                     parallel;
        logic                     overflow;
    } t_hit_out;

    // Shared divide operands, one set per ray
    typedef struct packed {
        logic [63:0] tmag;
        logic        tneg;
        logic [63:0] bmag;
        logic        bneg;
        logic        parallel;
    } t_quot_ctl;

    typedef struct packed {
        logic signed [WORD_W-1:0] coord;
        logic                     ovf;
    } t_coord_res;

endpackage

// ----- src/rpi_dot.sv -----
// ----------------------------------------------------------------------------
// Plane dot products
// Four-stage pipeline: products, partial sums, final sums, sign/magnitude.
// ----------------------------------------------------------------------------
module rpi_dot (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  rpi_pkg::t_ray_in          i_ray,
    input  logic signed [31:0]        i_plane_a,
    input  logic signed [31:0]        i_plane_b,
    input  logic signed [31:0]        i_plane_c,
    input  logic signed [31:0]        i_plane_d,
    output logic                      o_valid,
    output rpi_pkg::t_ray_in          o_ray,
    output rpi_pkg::t_quot_ctl        o_ctl
);

    logic [3:0]               r_vld;
    rpi_pkg::t_ray_in         r_ray [4];
    logic signed [63:0]       r_ps0, r_ps1, r_ps2, r_pd0, r_pd1, r_pd2;
    logic signed [65:0]       r_dterm;
    logic signed [65:0]       r_ta, r_tb, r_ba, r_bb;
    logic signed [65:0]       r_tsum, r_bsum;
    rpi_pkg::t_quot_ctl       r_ctl;
    logic signed [65:0]       n_tabs, n_babs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_comb begin
        n_tabs = r_tsum[65] ? -r_tsum : r_tsum;
        n_babs = r_bsum[65] ? -r_bsum : r_bsum;
    end

    always_ff @(posedge i_clk) begin
        r_ray[0] <= i_ray;
        r_ray[1] <= r_ray[0];
        r_ray[2] <= r_ray[1];
        r_ray[3] <= r_ray[2];
        // products
        r_ps0   <= 64'(i_plane_a) * 64'(i_ray.start_x);
        r_ps1   <= 64'(i_plane_b) * 64'(i_ray.start_y);
        r_ps2   <= 64'(i_plane_c) * 64'(i_ray.start_z);
        r_pd0   <= 64'(i_plane_a) * 64'(i_ray.dir_x);
        r_pd1   <= 64'(i_plane_b) * 64'(i_ray.dir_y);
        r_pd2   <= 64'(i_plane_c) * 64'(i_ray.dir_z);
        r_dterm <= 66'(i_plane_d) <<< rpi_pkg::FRAC_BITS;
        // partial sums
        r_ta <= 66'(r_ps0) + 66'(r_ps1);
        r_tb <= 66'(r_ps2) + r_dterm;
        r_ba <= 66'(r_pd0) + 66'(r_pd1);
        r_bb <= 66'(r_pd2);
        // full sums
        r_tsum <= r_ta + r_tb;
        r_bsum <= r_ba + r_bb;
        // top is the negated sum
        r_ctl.tmag     <= n_tabs[63:0];
        r_ctl.tneg     <= !r_tsum[65] && (r_tsum != '0);
        r_ctl.bmag     <= n_babs[63:0];
        r_ctl.bneg     <= r_bsum[65];
        r_ctl.parallel <= (r_bsum == '0);
    end

    assign o_valid = r_vld[3];
    assign o_ray   = r_ray[3];
    assign o_ctl   = r_ctl;

endmodule

// ----- src/rpi_div.sv -----
// ----------------------------------------------------------------------------
// Coordinate divide lane
// Forms start + dir*top/bottom, truncated toward zero, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rpi_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  rpi_pkg::t_quot_ctl        i_ctl,
    input  logic signed [31:0]        i_start,
    input  logic signed [31:0]        i_dir,
    output logic                      o_valid,
    output rpi_pkg::t_coord_res       o_res
);

    localparam int NS = rpi_pkg::DIV_STEPS;
    localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
    localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

    typedef struct packed {
        logic [63:0]        rem;
        logic [NS-1:0]      low;
        logic [NS-1:0]      quo;
        logic signed [31:0] s;
        logic [63:0]        bmag;
        logic               neg;
        logic               big;
        logic               par;
    } t_div_lane;

    logic                 r_a_vld, r_b_vld, r_o_vld;
    logic [NS:0]          r_lvld;
    logic [63:0]          r_pl, r_ph;
    logic                 r_a_neg, r_b_neg, r_a_par, r_b_par;
    logic signed [31:0]   r_a_s, r_b_s;
    logic [63:0]          r_a_bmag, r_b_bmag;
    logic [95:0]          r_num;
    t_div_lane            r_lane [NS+1];
    rpi_pkg::t_coord_res  r_res;

    logic [31:0]          n_dm;
    logic signed [34:0]   n_sum;
    logic signed [34:0]   n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_lvld  <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_lvld  <= {r_lvld[NS-1:0], r_b_vld};
            r_o_vld <= r_lvld[NS];
        end
    end

    assign n_dm = i_dir[31] ? 32'(-i_dir) : 32'(i_dir);

    always_ff @(posedge i_clk) begin
        // split 64x32 product into two 32x32 halves
        r_pl     <= 64'(i_ctl.tmag[31:0]) * 64'(n_dm);
        r_ph     <= 64'(i_ctl.tmag[63:32]) * 64'(n_dm);
        r_a_neg  <= i_dir[31] ^ i_ctl.tneg ^ i_ctl.bneg;
        r_a_s    <= i_start;
        r_a_bmag <= i_ctl.bmag;
        r_a_par  <= i_ctl.parallel;

        r_num    <= {32'd0, r_pl} + {r_ph, 32'd0};
        r_b_neg  <= r_a_neg;
        r_b_s    <= r_a_s;
        r_b_bmag <= r_a_bmag;
        r_b_par  <= r_a_par;

        // quotient fits in NS bits only if num >> NS < bmag
        r_lane[0].rem  <= {1'b0, r_num[95:NS]};
        r_lane[0].low  <= r_num[NS-1:0];
        r_lane[0].quo  <= '0;
        r_lane[0].s    <= r_b_s;
        r_lane[0].bmag <= r_b_bmag;
        r_lane[0].neg  <= r_b_neg;
        r_lane[0].big  <= {1'b0, r_num[95:NS]} >= r_b_bmag;
        r_lane[0].par  <= r_b_par;
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [64:0] n_shift;
        logic [64:0] n_diff;
        logic        n_ge;
        t_div_lane   n_lane;

        always_comb begin
            n_shift    = {r_lane[k].rem, r_lane[k].low[NS-1]};
            n_diff     = n_shift - {1'b0, r_lane[k].bmag};
            n_ge       = n_shift >= {1'b0, r_lane[k].bmag};
            n_lane     = r_lane[k];
            n_lane.rem = n_ge ? n_diff[63:0] : n_shift[63:0];
            n_lane.low = {r_lane[k].low[NS-2:0], 1'b0};
            n_lane.quo = {r_lane[k].quo[NS-2:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            r_lane[k+1] <= n_lane;
        end
    end

    always_comb begin
        n_q   = $signed({2'b00, r_lane[NS].quo});
        n_sum = r_lane[NS].neg ? 35'(r_lane[NS].s) - n_q : 35'(r_lane[NS].s) + n_q;
    end

    always_ff @(posedge i_clk) begin
        if (r_lane[NS].par) begin
            r_res.coord <= r_lane[NS].s;
            r_res.ovf   <= 1'b0;
        end else if (r_lane[NS].big) begin
            r_res.coord <= r_lane[NS].neg ? 32'sh80000000 : 32'sh7FFFFFFF;
            r_res.ovf   <= 1'b1;
        end else if (n_sum > SAT_HI) begin
            r_res.coord <= 32'sh7FFFFFFF;
            r_res.ovf   <= 1'b1;
        end else if (n_sum < SAT_LO) begin
            r_res.coord <= 32'sh80000000;
            r_res.ovf   <= 1'b1;
        end else begin
            r_res.coord <= n_sum[31:0];
            r_res.ovf   <= 1'b0;
        end
    end

    assign o_valid = r_o_vld;
    assign o_res   = r_res;

endmodule

// ----- src/ray_plane_intersect_top.sv -----
// ----------------------------------------------------------------------------
// Ray / plane intersection
// Pipelined fixed-point intersection of rays with a configured plane.
// ----------------------------------------------------------------------------
// Usage:
//   Load plane_a/b/c/offset through the cfg channel (index, data, valid/ready;
//   ready is always high). Write config only while no request is in flight.
//   Present a ray on i_ray with start high; busy is always low, so one
//   request is taken every cycle.
//   Each result appears on o_hit for one cycle with o_done high; results
//   leave in request order. The path runs through 4 dot-product stages,
//   3 multiply/compare stages, 33 quotient-bit stages (one per stage) and
//   one saturation stage. Throughput is one ray per cycle.
//   The receiver cannot stall; results must be taken when o_done is high.
//   Reset clears all plane registers to zero and drops every request in
//   flight.
// ----------------------------------------------------------------------------
module ray_plane_intersect_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  rpi_pkg::t_ray_in                   i_ray,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rpi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rpi_pkg::WORD_W-1:0]         i_cfg_data,
    output logic                               o_done,
    output rpi_pkg::t_hit_out                  o_hit
);

    logic signed [31:0]  r_plane_a, r_plane_b, r_plane_c, r_plane_d;
    logic                dot_vld;
    rpi_pkg::t_ray_in    dot_ray;
    rpi_pkg::t_quot_ctl  dot_ctl;
    logic                vld_x, vld_y, vld_z;
    rpi_pkg::t_coord_res res_x, res_y, res_z;
    logic                r_par_d [37];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_a <= '0;
            r_plane_b <= '0;
            r_plane_c <= '0;
            r_plane_d <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rpi_pkg::CFG_PLANE_A:      r_plane_a <= i_cfg_data;
                rpi_pkg::CFG_PLANE_B:      r_plane_b <= i_cfg_data;
                rpi_pkg::CFG_PLANE_C:      r_plane_c <= i_cfg_data;
                rpi_pkg::CFG_PLANE_OFFSET: r_plane_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rpi_dot u_dot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_ray     (i_ray),
        .i_plane_a (r_plane_a),
        .i_plane_b (r_plane_b),
        .i_plane_c (r_plane_c),
        .i_plane_d (r_plane_d),
        .o_valid   (dot_vld),
        .o_ray     (dot_ray),
        .o_ctl     (dot_ctl)
    );

    rpi_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (dot_vld), .i_ctl (dot_ctl),
        .i_start (dot_ray.start_x), .i_dir (dot_ray.dir_x),
        .o_valid (vld_x), .o_res (res_x)
    );

    rpi_div u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (dot_vld), .i_ctl (dot_ctl),
        .i_start (dot_ray.start_y), .i_dir (dot_ray.dir_y),
        .o_valid (vld_y), .o_res (res_y)
    );

    rpi_div u_div_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (dot_vld), .i_ctl (dot_ctl),
        .i_start (dot_ray.start_z), .i_dir (dot_ray.dir_z),
        .o_valid (vld_z), .o_res (res_z)
    );

    // delay parallel flag alongside the divide lanes
    always_ff @(posedge i_clk) begin
        r_par_d[0] <= dot_ctl.parallel;
        for (int i = 1; i < 37; i++) begin
            r_par_d[i] <= r_par_d[i-1];
        end
    end

    assign o_done         = vld_x;
    assign o_hit.hit_x    = res_x.coord;
    assign o_hit.hit_y    = res_y.coord;
    assign o_hit.hit_z    = res_z.coord;
    assign o_hit.parallel = r_par_d[36];
    assign o_hit.overflow = res_x.ovf | res_y.ovf | res_z.ovf;

    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld_x == vld_y) && (vld_x == vld_z))
        else $error("divide lanes out of step");

    a_parallel_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_hit.parallel |-> !o_hit.overflow)
        else $error("overflow flagged on parallel ray");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && (i_cfg_index == rpi_pkg::CFG_PLANE_A) |=> r_plane_a == $past(i_cfg_data))
        else $error("plane_a write lost");

endmodule
